/* rtl/core/srocc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srocc_pkg
// Shared widths, fixed-point constants and the arctangent table for the
// sonar ray occupancy cell block.
// ----------------------------------------------------------------------------
package srocc_pkg;

  // default sizing of the top level
  localparam int DEF_MAX_RANGE_BINS = 64;
  localparam int DEF_MAX_BEAMS      = 1024;
  localparam int DEF_CORDIC_STEPS   = 16;

  // datapath widths
  localparam int XW    = 56;   // cordic x / y datapath
  localparam int ANG_W = 28;   // angles in microradians
  localparam int SQ_W  = 37;   // sum of squares
  localparam int RNG_W = 19;   // range, point mode reaches above 18 bits

  // angle constants in microradians
  localparam logic signed [ANG_W-1:0] PI_URAD      = 28'sd3141593;
  localparam logic signed [ANG_W-1:0] PI_M1_URAD   = 28'sd3141592;
  localparam logic signed [ANG_W-1:0] HALF_PI_URAD = 28'sd1570796;
  localparam logic signed [ANG_W-1:0] TWO_PI_URAD  = 28'sd6283185;

  // cordic gain compensation, q30
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  // ceil(2^37 / 1000), exact floor divide by 1000 for values below 2^27
  localparam logic signed [31:0] MRAD_RECIP = 32'sd137438954;
  localparam int MRAD_SHIFT = 37;
  localparam logic [ANG_W-1:0] MRAD_HALF = 28'd500;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_MODE  = 3'd0;
  localparam logic [2:0] CFG_RANGE_STEP  = 3'd1;
  localparam logic [2:0] CFG_RANGE_MIN   = 3'd2;
  localparam logic [2:0] CFG_RANGE_MAX   = 3'd3;
  localparam logic [2:0] CFG_ANGLE_START = 3'd4;
  localparam logic [2:0] CFG_ANGLE_STEP  = 3'd5;

  // atan(2^-i) in microradians, rounded
  function automatic logic [19:0] atan_urad(input logic [4:0] i);
    logic [19:0] v;
    unique case (i)
      5'd0:  v = 20'd785398;
      5'd1:  v = 20'd463648;
      5'd2:  v = 20'd244979;
      5'd3:  v = 20'd124355;
      5'd4:  v = 20'd62419;
      5'd5:  v = 20'd31240;
      5'd6:  v = 20'd15624;
      5'd7:  v = 20'd7812;
      5'd8:  v = 20'd3906;
      5'd9:  v = 20'd1953;
      5'd10: v = 20'd977;
      5'd11: v = 20'd488;
      5'd12: v = 20'd244;
      5'd13: v = 20'd122;
      5'd14: v = 20'd61;
      5'd15: v = 20'd31;
      5'd16: v = 20'd15;
      5'd17: v = 20'd8;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      5'd20: v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/srocc_cordic_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srocc_cordic_step
// One cordic micro-rotation, shared by vectoring and rotating passes.
// ----------------------------------------------------------------------------
module srocc_cordic_step
  import srocc_pkg::*;
(
  input  wire logic signed [XW-1:0]    x_i,
  input  wire logic signed [XW-1:0]    y_i,
  input  wire logic signed [ANG_W-1:0] z_i,
  input  wire logic [4:0]              shift_i,
  input  wire logic                    dir_pos_i,
  output logic signed [XW-1:0]         x_o,
  output logic signed [XW-1:0]         y_o,
  output logic signed [ANG_W-1:0]      z_o
);

  logic signed [XW-1:0]    xs;
  logic signed [XW-1:0]    ys;
  logic signed [ANG_W-1:0] at;

  assign xs = x_i >>> shift_i;
  assign ys = y_i >>> shift_i;
  assign at = signed'({{(ANG_W-20){1'b0}}, atan_urad(shift_i)});

  // counterclockwise when dir_pos_i, clockwise otherwise
  always_comb begin
    if (dir_pos_i) begin
      x_o = x_i - ys;
      y_o = y_i + xs;
      z_o = z_i - at;
    end else begin
      x_o = x_i + ys;
      y_o = y_i - xs;
      z_o = z_i + at;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sonar_ray_occupancy_cells.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sonar_ray_occupancy_cells
// Turns one sonar beam into a run of polar occupancy cells.
// ----------------------------------------------------------------------------
// Usage:
//  in_* takes one beam per transaction. frame_mode 0 reads point_y/point_z
//  and derives range (bit-serial square root) and angle (vectoring cordic,
//  skipped for a point at the origin). frame_mode 1 reads beam_index,
//  range_mm and range_finite; dropped beams return to idle with no output.
//  Per beam the angle is then turned into milliradians and reduced by one
//  turn of two pi per step, and the range bin is found by a restoring
//  divide. Each cell is then rotated on the shared micro-rotation unit.
//  in_tready is high only while idle; one beam is worked at a time.
//  out_* carries free cells from bin 0 up, then the hit cell with tlast.
//  The output register lets the next cell be computed while the current one
//  waits; a stalled receiver holds the sequencer at its emit step.
//  Reset (synchronous, active low) loads the register defaults and empties
//  the output. cfg_* writes a register. The user must write it only while
//  the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sonar_ray_occupancy_cells
  import srocc_pkg::*;
#(
  parameter int MAX_RANGE_BINS = DEF_MAX_RANGE_BINS,
  parameter int MAX_BEAMS      = DEF_MAX_BEAMS,
  parameter int CORDIC_STEPS   = DEF_CORDIC_STEPS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write port
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [22:0] cfg_wdata,
  // beam input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // beam_index[9:0], range_mm[27:10], range_finite[28], point_y_mm[47:29],
  // point_z_mm[66:48], zero fill
  input  wire logic [71:0] in_tdata,
  // cell output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // range_bin[5:0], angle_bin[21:6], pos_x_mm[45:22], pos_y_mm[69:46],
  // pos_z_mm[93:70], range_clipped[94], zero fill
  output logic [95:0]      out_tdata,
  // occupied[0]
  output logic [0:0]       out_tuser,
  output logic             out_tlast
);

  typedef enum logic [4:0] {
    S_IDLE, S_SMUL, S_SANG, S_SQY, S_SQZ, S_SSUM, S_SQRT, S_VINIT, S_VEC,
    S_RMUL, S_RDIV, S_RED, S_WRAP, S_FOLD, S_DIV, S_CMUL, S_CINIT, S_ROT,
    S_EMIT
  } state_t;

  localparam int BCMP_W = 13;
  localparam logic [4:0] ROT_LAST  = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0] SQRT_LAST = 5'd18;
  localparam logic [4:0] DIV_LAST  = 5'd18;
  localparam logic [5:0] BIN_LAST  = 6'(MAX_RANGE_BINS - 1);

  // configuration registers
  logic                     frame_mode_r;
  logic [15:0]              range_step_r;
  logic [17:0]              range_min_r;
  logic [17:0]              range_max_r;
  logic signed [22:0]       angle_start_r;
  logic signed [16:0]       angle_step_r;
  logic [15:0]              step_eff;

  // sequencer and datapath registers
  state_t                   state_r;
  logic [4:0]               cnt_r;
  logic                     mode_r;
  logic [9:0]               idx_r;
  logic signed [18:0]       pt_y_r;
  logic signed [18:0]       pt_z_r;
  logic [RNG_W-1:0]         r_r;
  logic signed [63:0]       prod_r;
  logic [SQ_W-1:0]          sq_n_r;
  logic [SQ_W-1:0]          sq_res_r;
  logic [SQ_W-1:0]          sq_bit_r;
  logic signed [ANG_W-1:0]  ang_r;
  logic signed [15:0]       mrad_r;
  logic signed [ANG_W-1:0]  rot_r;
  logic                     flip_r;
  logic [RNG_W-1:0]         dq_r;
  logic [15:0]              rem_r;
  logic [5:0]               hit_r;
  logic                     clip_r;
  logic [5:0]               bin_r;
  logic [22:0]              r2_r;
  logic signed [XW-1:0]     cx_r;
  logic signed [XW-1:0]     cy_r;
  logic signed [ANG_W-1:0]  cz_r;

  // output register
  logic                     out_valid_r;
  logic [5:0]               o_bin_r;
  logic signed [15:0]       o_ang_r;
  logic                     o_occ_r;
  logic signed [23:0]       o_px_r;
  logic signed [23:0]       o_py_r;
  logic signed [23:0]       o_pz_r;
  logic                     o_clip_r;

  // input fields
  logic [9:0]               f_idx;
  logic [17:0]              f_range;
  logic                     f_finite;
  logic                     scan_drop;
  logic                     in_fire;

  assign f_idx    = in_tdata[9:0];
  assign f_range  = in_tdata[27:10];
  assign f_finite = in_tdata[28];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign step_eff  = (range_step_r == 16'd0) ? 16'd1 : range_step_r;

  assign scan_drop = !f_finite
                  || ({{(BCMP_W-10){1'b0}}, f_idx} >= BCMP_W'(MAX_BEAMS))
                  || (f_range < range_min_r) || (f_range > range_max_r);

  // shared multiplier operand select
  logic signed [31:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic [ANG_W-1:0]        ang_mag;

  assign ang_mag = (ang_r[ANG_W-1] ? 28'(-ang_r) : 28'(ang_r)) + MRAD_HALF;

  always_comb begin
    unique case (state_r)
      S_SMUL: begin
        mul_a = signed'({22'd0, idx_r});
        mul_b = {{15{angle_step_r[16]}}, angle_step_r};
      end
      S_SQY: begin
        mul_a = {{13{pt_y_r[18]}}, pt_y_r};
        mul_b = {{13{pt_y_r[18]}}, pt_y_r};
      end
      S_SQZ: begin
        mul_a = {{13{pt_z_r[18]}}, pt_z_r};
        mul_b = {{13{pt_z_r[18]}}, pt_z_r};
      end
      S_RMUL: begin
        mul_a = signed'({4'd0, ang_mag});
        mul_b = MRAD_RECIP;
      end
      S_CMUL: begin
        mul_a = signed'({9'd0, r2_r});
        mul_b = GAIN_Q30;
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  // shared cordic micro-rotation
  logic                    cdir;
  logic signed [XW-1:0]    cx_nxt;
  logic signed [XW-1:0]    cy_nxt;
  logic signed [ANG_W-1:0] cz_nxt;

  assign cdir = (state_r == S_VEC) ? cy_r[XW-1] : !cz_r[ANG_W-1];

  srocc_cordic_step u_step (
    .x_i      (cx_r),
    .y_i      (cy_r),
    .z_i      (cz_r),
    .shift_i  (cnt_r),
    .dir_pos_i(cdir),
    .x_o      (cx_nxt),
    .y_o      (cy_nxt),
    .z_o      (cz_nxt)
  );

  // square root step
  logic [SQ_W-1:0]         sq_t;
  logic                    sq_ge;
  logic [SQ_W-1:0]         sq_res_nxt;

  assign sq_t  = sq_res_r + sq_bit_r;
  assign sq_ge = (sq_n_r >= sq_t);
  assign sq_res_nxt = sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);

  // restoring divide step
  logic [16:0]             dv_t;
  logic                    dv_ge;
  logic [16:0]             dv_sub;
  logic [RNG_W-1:0]        dq_nxt;

  assign dv_t   = {rem_r, dq_r[RNG_W-1]};
  assign dv_ge  = (dv_t >= {1'b0, step_eff});
  assign dv_sub = dv_t - {1'b0, step_eff};
  assign dq_nxt = {dq_r[RNG_W-2:0], dv_ge};

  // milliradian rounding and saturation
  logic [16:0]             mq;
  logic signed [15:0]      mrad_nxt;
  logic signed [ANG_W-1:0] mrad_ext;
  logic signed [ANG_W-1:0] rot_nxt;

  assign mq = prod_r[MRAD_SHIFT+16:MRAD_SHIFT];

  always_comb begin
    if (ang_r[ANG_W-1]) begin
      mrad_nxt = (mq > 17'd32768) ? -16'sd32768 : 16'(-signed'({1'b0, mq}));
    end else begin
      mrad_nxt = (mq > 17'd32767) ? 16'sd32767 : 16'(mq);
    end
  end

  // times 1000 as 1024 - 16 - 8
  assign mrad_ext = {{(ANG_W-16){mrad_nxt[15]}}, mrad_nxt};
  assign rot_nxt  = (mrad_ext <<< 10) - (mrad_ext <<< 4) - (mrad_ext <<< 3);

  // angle wrap into [-pi, pi]
  logic signed [ANG_W-1:0] wr_a;
  logic signed [ANG_W-1:0] wr_b;

  assign wr_a = (rot_r > PI_M1_URAD) ? (rot_r - TWO_PI_URAD) : rot_r;
  assign wr_b = (wr_a < -PI_M1_URAD) ? (wr_a + TWO_PI_URAD) : wr_a;

  // output rounding of the rotated vector
  logic signed [XW-1:0]    rx_rnd;
  logic signed [XW-1:0]    ry_rnd;
  logic signed [23:0]      c_val;
  logic signed [23:0]      s_val;
  logic                    out_free;
  logic                    at_hit;

  assign rx_rnd   = cx_r + (XW'(1) <<< 30);
  assign ry_rnd   = cy_r + (XW'(1) <<< 30);
  assign c_val    = flip_r ? 24'(-rx_rnd[54:31]) : rx_rnd[54:31];
  assign s_val    = flip_r ? 24'(-ry_rnd[54:31]) : ry_rnd[54:31];
  assign out_free = !out_valid_r || out_tready;
  assign at_hit   = (bin_r == hit_r);

  // multiplier product register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= 5'd0;
      out_valid_r   <= 1'b0;
      frame_mode_r  <= 1'b0;
      range_step_r  <= 16'd1000;
      range_min_r   <= 18'd0;
      range_max_r   <= 18'd262143;
      angle_start_r <= 23'sd0;
      angle_step_r  <= 17'sd0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FRAME_MODE:  frame_mode_r  <= cfg_wdata[0];
          CFG_RANGE_STEP:  range_step_r  <= cfg_wdata[15:0];
          CFG_RANGE_MIN:   range_min_r   <= cfg_wdata[17:0];
          CFG_RANGE_MAX:   range_max_r   <= cfg_wdata[17:0];
          CFG_ANGLE_START: angle_start_r <= signed'(cfg_wdata[22:0]);
          CFG_ANGLE_STEP:  angle_step_r  <= signed'(cfg_wdata[16:0]);
          default: ;
        endcase
      end

      // output valid: loaded at the emit step, cleared once drained
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mode_r <= frame_mode_r;
            idx_r  <= f_idx;
            pt_y_r <= signed'(in_tdata[47:29]);
            pt_z_r <= signed'(in_tdata[66:48]);
            r_r    <= {1'b0, f_range};
            if (frame_mode_r) begin
              state_r <= scan_drop ? S_IDLE : S_SMUL;
            end else begin
              state_r <= S_SQY;
            end
          end
        end
        S_SMUL: state_r <= S_SANG;
        S_SANG: begin
          ang_r   <= {{(ANG_W-23){angle_start_r[22]}}, angle_start_r} + prod_r[ANG_W-1:0];
          state_r <= S_RMUL;
        end
        S_SQY: state_r <= S_SQZ;
        S_SQZ: begin
          sq_n_r  <= prod_r[SQ_W-1:0];
          state_r <= S_SSUM;
        end
        S_SSUM: begin
          sq_n_r   <= sq_n_r + prod_r[SQ_W-1:0];
          sq_res_r <= '0;
          sq_bit_r <= SQ_W'(1) << (SQ_W - 1);
          cnt_r    <= 5'd0;
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_n_r <= sq_n_r - sq_t;
          end
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r + 5'd1;
          if (cnt_r == SQRT_LAST) begin
            r_r     <= sq_res_nxt[RNG_W-1:0];
            state_r <= S_VINIT;
          end
        end
        S_VINIT: begin
          cnt_r <= 5'd0;
          if (pt_y_r == 19'sd0 && pt_z_r == 19'sd0) begin
            ang_r   <= '0;
            state_r <= S_RMUL;
          end else begin
            if (pt_z_r[18]) begin
              cx_r <= -({{(XW-19){pt_z_r[18]}}, pt_z_r} <<< 16);
              cy_r <= -({{(XW-19){pt_y_r[18]}}, pt_y_r} <<< 16);
              cz_r <= pt_y_r[18] ? -PI_URAD : PI_URAD;
            end else begin
              cx_r <= {{(XW-19){pt_z_r[18]}}, pt_z_r} <<< 16;
              cy_r <= {{(XW-19){pt_y_r[18]}}, pt_y_r} <<< 16;
              cz_r <= '0;
            end
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          cx_r  <= cx_nxt;
          cy_r  <= cy_nxt;
          cz_r  <= cz_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == ROT_LAST) begin
            ang_r   <= cz_nxt;
            state_r <= S_RMUL;
          end
        end
        S_RMUL: state_r <= S_RDIV;
        S_RDIV: begin
          mrad_r  <= mrad_nxt;
          rot_r   <= rot_nxt;
          state_r <= S_RED;
        end
        // truncating remainder by two pi, one subtraction a cycle
        S_RED: begin
          if (rot_r >= TWO_PI_URAD) begin
            rot_r <= rot_r - TWO_PI_URAD;
          end else if (rot_r <= -TWO_PI_URAD) begin
            rot_r <= rot_r + TWO_PI_URAD;
          end else begin
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          rot_r   <= wr_b;
          state_r <= S_FOLD;
        end
        // fold into the cordic range with a half turn
        S_FOLD: begin
          if (rot_r > HALF_PI_URAD) begin
            rot_r  <= rot_r - PI_URAD;
            flip_r <= 1'b1;
          end else if (rot_r < -HALF_PI_URAD) begin
            rot_r  <= rot_r + PI_URAD;
            flip_r <= 1'b1;
          end else begin
            flip_r <= 1'b0;
          end
          dq_r    <= r_r;
          rem_r   <= 16'd0;
          cnt_r   <= 5'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= dv_ge ? dv_sub[15:0] : dv_t[15:0];
          dq_r  <= dq_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == DIV_LAST) begin
            clip_r  <= (dq_nxt > RNG_W'(MAX_RANGE_BINS - 1));
            hit_r   <= (dq_nxt > RNG_W'(MAX_RANGE_BINS - 1)) ? BIN_LAST : dq_nxt[5:0];
            bin_r   <= 6'd0;
            r2_r    <= {7'd0, step_eff};
            state_r <= S_CMUL;
          end
        end
        S_CMUL: state_r <= S_CINIT;
        S_CINIT: begin
          cx_r    <= prod_r[XW-1:0];
          cy_r    <= '0;
          cz_r    <= rot_r;
          cnt_r   <= 5'd0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          cx_r  <= cx_nxt;
          cy_r  <= cy_nxt;
          cz_r  <= cz_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == ROT_LAST) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_bin_r     <= bin_r;
            o_ang_r     <= mrad_r;
            o_occ_r     <= at_hit;
            o_clip_r    <= at_hit && clip_r;
            o_py_r      <= s_val;
            o_px_r      <= mode_r ? c_val : 24'sd0;
            o_pz_r      <= mode_r ? 24'sd0 : c_val;
            if (at_hit) begin
              state_r <= S_IDLE;
            end else begin
              bin_r   <= bin_r + 6'd1;
              r2_r    <= r2_r + {6'd0, step_eff, 1'b0};
              state_r <= S_CMUL;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {1'b0, o_clip_r, o_pz_r, o_py_r, o_px_r, o_ang_r, o_bin_r};
  assign out_tuser[0] = o_occ_r;
  assign out_tlast    = o_occ_r;

  // clipped flag only on the hit cell, and a clipped hit cell sits at the last bin
  a_clip_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_clip_r |-> o_occ_r && (o_bin_r == BIN_LAST))
    else $error("clipped flag away from last bin hit cell");

  // a cell is emitted only from the emit step with room in the output register
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("output loaded outside the emit step");

  // emitting the hit cell ends the beam
  a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_free && at_hit |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after the hit cell");

  // free cells never pass the hit bin
  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> bin_r <= hit_r)
    else $error("cell bin beyond hit bin");

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sonar_ray_occupancy_cells. A driver feeds beams and
// register writes from a queue, a behavioral model predicts every cell, and
// a monitor compares each output transaction with the oldest predicted cell.
// ----------------------------------------------------------------------------
module tb_top;
  import srocc_pkg::*;

  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  SETTLE_CYCLES  = 400;
  localparam int  MAX_BINS       = 64;
  localparam int  ROT_STEPS      = 16;

  typedef enum logic [1:0] {OP_BEAM, OP_CFG, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e           kind;
    logic [9:0]         idx;
    logic [17:0]        rng;
    logic               fin;
    logic signed [18:0] py;
    logic signed [18:0] pz;
    logic [2:0]         reg_idx;
    logic [22:0]        reg_val;
  } op_t;

  typedef struct {
    logic [5:0]  bin;
    logic [15:0] ang;
    logic        occ;
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] pz;
    logic        clip;
    logic        last;
  } cell_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = CFG_FRAME_MODE;
  logic [22:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  op_t   pending_ops[$];
  cell_t expected_cells[$];
  op_t   cur_beam;

  // shadow copy of the register file
  logic        sh_mode = 1'b0;
  logic [15:0] sh_step = 16'd1000;
  logic [17:0] sh_rmin = 18'd0;
  logic [17:0] sh_rmax = 18'd262143;
  longint      sh_astart = 0;
  longint      sh_astep = 0;

  int errors = 0;
  int beams_sent = 0;
  int beams_dropped = 0;
  int cells_seen = 0;
  int quiet_cycles = 0;
  int stall_cycles = 0;
  int cycle_cnt = 0;

  longint arctab[ROT_STEPS] = '{785398, 463648, 244979, 124355, 62419, 31240,
                                15624, 7812, 3906, 1953, 977, 488, 244, 122,
                                61, 31};

  sonar_ray_occupancy_cells dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint point_angle(longint y, longint z);
    longint x, w, acc, xs, ws;
    x = z * 65536;
    w = y * 65536;
    acc = 0;
    if (y == 0 && z == 0) return 0;
    if (x < 0) begin
      acc = (w >= 0) ? 3141593 : -3141593;
      x = -x;
      w = -w;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ws = w >>> i;
      if (w >= 0) begin
        x += ws; w -= xs; acc += arctab[i];
      end else begin
        x -= ws; w += xs; acc -= arctab[i];
      end
    end
    return acc;
  endfunction

  function automatic longint to_mrad(longint a);
    longint m;
    m = ((a < 0 ? -a : a) + 500) / 1000;
    if (a < 0) m = -m;
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    return m;
  endfunction

  // r2 is twice the cell centre radius; returns radius*cos and radius*sin
  task automatic cell_centre(input longint r2, input longint ang,
                             output longint c, output longint s);
    longint x, y, a, xs, ys;
    bit flip;
    x = r2 * 652032874;
    y = 0;
    a = ang % 6283185;
    flip = 0;
    if (a > 3141592) a -= 6283185;
    if (a < -3141592) a += 6283185;
    if (a > 1570796) begin
      a -= 3141593; flip = 1;
    end else if (a < -1570796) begin
      a += 3141593; flip = 1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= arctab[i];
      end else begin
        x += ys; y -= xs; a += arctab[i];
      end
    end
    x = (x + (64'sd1 <<< 30)) >>> 31;
    y = (y + (64'sd1 <<< 30)) >>> 31;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // expected cells of one accepted beam
  task automatic predict_cells(input op_t b);
    longint r, stepv, hit, mrad, c, s, y, z;
    bit clipped;
    cell_t e;
    if (sh_mode) begin
      if (!b.fin || b.rng < sh_rmin || b.rng > sh_rmax) begin
        beams_dropped++;
        return;
      end
      r = b.rng;
      mrad = to_mrad(sh_astart + longint'(b.idx) * sh_astep);
    end else begin
      y = b.py;
      z = b.pz;
      r = int_sqrt(y * y + z * z);
      mrad = to_mrad(point_angle(y, z));
    end
    stepv = (sh_step == 0) ? 1 : sh_step;
    hit = r / stepv;
    clipped = hit > MAX_BINS - 1;
    if (clipped) hit = MAX_BINS - 1;
    for (longint bn = 0; bn <= hit; bn++) begin
      cell_centre((2 * bn + 1) * stepv, mrad * 1000, c, s);
      e.bin  = bn[5:0];
      e.ang  = mrad[15:0];
      e.occ  = (bn == hit);
      e.px   = sh_mode ? c[23:0] : 24'd0;
      e.py   = s[23:0];
      e.pz   = sh_mode ? 24'd0 : c[23:0];
      e.clip = (bn == hit) && clipped;
      e.last = (bn == hit);
      expected_cells.push_back(e);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    logic       nx_valid, nx_wr;
    logic [71:0] nx_data;
    logic [2:0] nx_idx;
    logic [22:0] nx_wdata;
    bit         no_idle;
    op_t        head;
    nx_valid = in_tvalid;
    nx_data  = in_tdata;
    nx_wr    = 1'b0;
    nx_idx   = cfg_index;
    nx_wdata = cfg_wdata;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_cells(cur_beam);
        nx_valid = 1'b0;
      end
      quiet_cycles = (expected_cells.size() == 0 && !in_tvalid) ? quiet_cycles + 1 : 0;
      no_idle = beams_sent >= 150 && beams_sent < 230;
      if (!nx_valid && pending_ops.size() != 0) begin
        head = pending_ops[0];
        case (head.kind)
          OP_BEAM: begin
            if (no_idle || $urandom_range(99) >= 13) begin
              nx_data = '0;
              nx_data[9:0]   = head.idx;
              nx_data[27:10] = head.rng;
              nx_data[28]    = head.fin;
              nx_data[47:29] = head.py;
              nx_data[66:48] = head.pz;
              nx_valid = 1'b1;
              cur_beam = head;
              beams_sent++;
              void'(pending_ops.pop_front());
            end
          end
          OP_DRAIN: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(pending_ops.pop_front());
          end
          default: begin
            nx_wr = 1'b1;
            nx_idx = head.reg_idx;
            nx_wdata = head.reg_val;
            case (head.reg_idx)
              CFG_FRAME_MODE:  sh_mode = head.reg_val[0];
              CFG_RANGE_STEP:  sh_step = head.reg_val[15:0];
              CFG_RANGE_MIN:   sh_rmin = head.reg_val[17:0];
              CFG_RANGE_MAX:   sh_rmax = head.reg_val[17:0];
              CFG_ANGLE_START: sh_astart = longint'($signed(head.reg_val[22:0]));
              CFG_ANGLE_STEP:  sh_astep = longint'($signed(head.reg_val[16:0]));
              default: ;
            endcase
            void'(pending_ops.pop_front());
          end
        endcase
      end
    end
    in_tvalid <= nx_valid;
    in_tdata  <= nx_data;
    cfg_wr_en <= nx_wr;
    cfg_index <= nx_idx;
    cfg_wdata <= nx_wdata;
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    cell_t e;
    cycle_cnt++;
    if (rst_n && out_tvalid && out_tready) begin
      cells_seen++;
      if (expected_cells.size() == 0) begin
        report("unexpected cell, bin", out_tdata[5:0], -1);
      end else begin
        e = expected_cells.pop_front();
        if (out_tdata[5:0] != e.bin) report("range_bin", out_tdata[5:0], e.bin);
        if (out_tdata[21:6] != e.ang)
          report("angle_bin", $signed(out_tdata[21:6]), $signed(e.ang));
        if (out_tuser[0] != e.occ) report("occupied", out_tuser[0], e.occ);
        if (out_tdata[45:22] != e.px)
          report("pos_x_mm", $signed(out_tdata[45:22]), $signed(e.px));
        if (out_tdata[69:46] != e.py)
          report("pos_y_mm", $signed(out_tdata[69:46]), $signed(e.py));
        if (out_tdata[93:70] != e.pz)
          report("pos_z_mm", $signed(out_tdata[93:70]), $signed(e.pz));
        if (out_tdata[94] != e.clip) report("range_clipped", out_tdata[94], e.clip);
        if (out_tlast != e.last) report("last", out_tlast, e.last);
      end
    end
    // receiver stalls, with one stretch of steady acceptance
    if (cycle_cnt > 20000 && cycle_cnt < 40000) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 13);
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d cells outstanding", expected_cells.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_beam(input logic [9:0] idx, input logic [17:0] rng, input logic fin,
                          input logic signed [18:0] py, input logic signed [18:0] pz);
    op_t o;
    o.kind = OP_BEAM; o.idx = idx; o.rng = rng; o.fin = fin; o.py = py; o.pz = pz;
    o.reg_idx = CFG_FRAME_MODE; o.reg_val = '0;
    pending_ops.push_back(o);
  endtask

  task automatic add_write(input logic [2:0] ri, input longint v);
    op_t o;
    o.kind = OP_CFG; o.reg_idx = ri; o.reg_val = v[22:0];
    o.idx = '0; o.rng = '0; o.fin = 1'b0; o.py = '0; o.pz = '0;
    pending_ops.push_back(o);
  endtask

  task automatic add_drain();
    op_t o;
    o.kind = OP_DRAIN; o.reg_idx = CFG_FRAME_MODE; o.reg_val = '0;
    o.idx = '0; o.rng = '0; o.fin = 1'b0; o.py = '0; o.pz = '0;
    pending_ops.push_back(o);
  endtask

  task automatic set_regs(input longint mode, stp, rmin, rmax, ast, asp);
    add_drain();
    add_write(CFG_FRAME_MODE, mode);
    add_write(CFG_RANGE_STEP, stp);
    add_write(CFG_RANGE_MIN, rmin);
    add_write(CFG_RANGE_MAX, rmax);
    add_write(CFG_ANGLE_START, ast);
    add_write(CFG_ANGLE_STEP, asp);
  endtask

  // random beam with noise in the fields of the other mode
  task automatic add_random_beam(input bit mode, input longint stp, rmin, rmax);
    longint lim, lo, hi;
    logic [9:0] idx;
    logic [17:0] rng;
    logic fin;
    logic signed [18:0] py, pz;
    idx = $urandom; rng = $urandom; fin = $urandom; py = $urandom; pz = $urandom;
    if (stp == 0) stp = 1;
    if (!mode) begin
      if ($urandom_range(99) < 85) begin
        lim = stp * $urandom_range(1, 30);
        if (lim > 262143) lim = 262143;
        py = $urandom_range(0, 2 * lim) - lim;
        pz = $urandom_range(0, 2 * lim) - lim;
      end else begin
        py = $urandom_range(0, 524286) - 262143;
        pz = $urandom_range(0, 524286) - 262143;
      end
    end else begin
      fin = ($urandom_range(99) < 90);
      if (rmin <= rmax && $urandom_range(99) < 85) begin
        lo = rmin;
        hi = rmin + stp * $urandom_range(1, 40);
        if (hi > rmax) hi = rmax;
        rng = $urandom_range(lo, hi);
      end
    end
    add_beam(idx, rng, fin, py, pz);
  endtask

  initial begin
    longint stp, rmin, rmax;
    // reset defaults: point mode, 1 m bins
    add_beam(0, 0, 0, 0, 0);
    add_beam(1023, 262143, 1, 262143, 262143);
    add_beam(0, 0, 0, -262143, -262143);
    add_beam(0, 0, 0, 0, -5000);
    add_beam(0, 0, 0, -3000, -100);
    add_beam(0, 0, 0, 1500, 2500);
    add_beam(0, 0, 0, -1, 1);
    add_beam(0, 0, 0, 262143, 0);
    // scan mode, window edges and dropped beams
    set_regs(1, 4000, 1000, 200000, -3141593, 65535);
    add_beam(0, 5000, 1, 0, 0);
    add_beam(1023, 200000, 1, 0, 0);
    add_beam(5, 9000, 0, 0, 0);
    add_beam(6, 999, 1, 0, 0);
    add_beam(7, 200001, 1, 0, 0);
    add_beam(8, 1000, 1, 0, 0);
    // zero step acts as one, saturated angles
    set_regs(1, 0, 0, 262143, 3141593, -65535);
    add_beam(0, 0, 1, 0, 0);
    add_beam(1023, 63, 1, 0, 0);
    add_beam(512, 262143, 1, 0, 0);
    // inverted window drops everything
    set_regs(1, 65535, 5000, 100, 0, 1);
    add_beam(3, 3000, 1, 0, 0);
    add_beam(4, 50, 1, 0, 0);
    // widest bins
    set_regs(1, 65535, 0, 262143, 1000, 0);
    add_beam(9, 262143, 1, 0, 0);
    set_regs(0, 65535, 0, 262143, 0, 0);
    add_beam(0, 0, 0, 262143, -262143);
    add_beam(0, 0, 0, -200000, 150000);

    // random phases
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(3))
        0: stp = 1 + $urandom_range(63);
        1: stp = 65535;
        default: stp = $urandom_range(500, 20000);
      endcase
      rmin = $urandom_range(0, 20000);
      rmax = (p == 3) ? rmin / 2 : $urandom_range(rmin + 1000, 262143);
      set_regs(p % 2, stp, rmin, rmax, $urandom_range(0, 6283186) - 3141593,
               $urandom_range(0, 131070) - 65535);
      for (int i = 0; i < 64; i++) begin
        if (i == 32) add_drain();
        add_random_beam(p % 2, stp, rmin, rmax);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !in_tvalid && expected_cells.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d beams (%0d dropped) and %0d cells over point and scan modes",
             beams_sent, beams_dropped, cells_seen);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d cells outstanding", errors, expected_cells.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sonar_ray_occupancy_cells.f */
rtl/core/srocc_pkg.sv
rtl/core/srocc_cordic_step.sv
rtl/core/sonar_ray_occupancy_cells.sv
test/tb_top.sv
